/* hw/rtl/pbl_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helpers for the pad button latch block.
package pbl_pkg;

	localparam int CNT_BITS   = 16;              // hold counter width
	localparam int NUM_BTN    = 16;
	localparam int NUM_CNT    = 8;               // counted buttons
	localparam int CMP_W      = CNT_BITS + 1;    // width for delay compares
	localparam int BCNT_W     = $clog2(CNT_BITS);
	localparam int OUT_W      = 56;              // 32 + 16 + 1 packed, padded to bytes

	localparam logic [31:0] COUNTED_MASK = 32'hf00f_f00f;
	localparam logic [15:0] EDGE_MASK    = 16'h0ff0;
	localparam logic [15:0] DIR_MASK     = 16'hf000;
	localparam logic [15:0] RESET_COMBO  = 16'h090c;
	localparam logic [4:0]  TIMER_THR    = 5'd4;
	localparam logic [4:0]  TIMER_MAX    = 5'd10;
	localparam logic [8:0]  SEC_EXTRA    = 9'd2;

	// register indexes on the configuration port
	localparam logic [1:0] REG_SPEED  = 2'd0;
	localparam logic [1:0] REG_DELAY  = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;
	localparam logic [1:0] REG_SECOND = 2'd3;

	// one classified sample passed from front to back
	typedef struct packed {
		logic [15:0] cur;
		logic [15:0] held;
		logic        rst_req;
	} item_t;

	// delay settings handed to the back part
	typedef struct packed {
		logic [3:0] speed;
		logic [7:0] delay;
		logic [7:0] period;
		logic [7:0] second;
	} cfg_t;

	// pad button bit served by hold counter k
	function automatic logic [3:0] btn_of(input logic [2:0] k);
		btn_of = k[2] ? {2'b11, k[1:0]} : {2'b00, k[1:0]};
	endfunction

endpackage

/* hw/rtl/pbl_fifo.sv */
`timescale 1ns / 1ps
// Two-entry queue between the front and back parts.
module pbl_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pbl_pkg::item_t   wdata,
	input  logic             pop,
	output pbl_pkg::item_t   rdata,
	output logic             full,
	output logic             empty
);

	pbl_pkg::item_t mem_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rptr_q];

	// store on push
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hw/rtl/pbl_front.sv */
`timescale 1ns / 1ps
// Front part: button latch, activation timer and press edge detection.
module pbl_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [15:0]      pad,
	input  logic [3:0]       speed,
	output pbl_pkg::item_t   item
);

	logic [15:0] latch_q;
	logic [4:0]  timer_q;
	logic [15:0] prev_q;

	logic [15:0] cur;
	logic [15:0] latch_d;
	logic [4:0]  timer_d;
	logic [4:0]  timer_a;
	logic [15:0] pick;

	// latch and pick the button seen this frame
	always_comb begin
		cur     = pad;
		latch_d = latch_q;
		timer_d = timer_q;
		timer_a = timer_q;
		pick    = pad;
		if ((pad & latch_q) != 16'd0) begin
			cur = pad & latch_q;
		end else if (pad == 16'd0) begin
			latch_d = 16'd0;
			timer_d = timer_q + {1'b0, speed};
		end else begin
			if (timer_q < pbl_pkg::TIMER_THR && (pad & pbl_pkg::DIR_MASK) != 16'd0) begin
				pick    = pad & pbl_pkg::DIR_MASK;
				timer_a = pbl_pkg::TIMER_MAX;
			end
			if (timer_a >= pbl_pkg::TIMER_THR) begin
				timer_d = 5'd0;
				cur     = pick & (~pick + 16'd1);
				latch_d = cur;
			end else begin
				timer_d = timer_a;
				cur     = 16'd0;
				latch_d = 16'd0;
			end
		end
		if (timer_d >= pbl_pkg::TIMER_MAX) begin
			timer_d = pbl_pkg::TIMER_MAX;
		end
	end

	assign item.cur     = cur;
	assign item.held    = cur & ~prev_q & pbl_pkg::EDGE_MASK;
	assign item.rst_req = (pad == pbl_pkg::RESET_COMBO);

	// update state on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 16'd0;
			timer_q <= 5'd0;
			prev_q  <= 16'd0;
		end else if (take) begin
			latch_q <= latch_d;
			timer_q <= timer_d;
			prev_q  <= cur;
		end
	end

endmodule

/* hw/rtl/pbl_back.sv */
`timescale 1ns / 1ps
// Back part: scaled delays, serial walk over the hold counters, result assembly.
module pbl_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       empty,
	input  pbl_pkg::item_t             item,
	input  pbl_pkg::cfg_t              cfg,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [pbl_pkg::OUT_W-1:0]  out_data
);

	typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_LOAD, ST_MOD, ST_EVAL, ST_OUT} state_t;

	state_t                          state_q;
	pbl_pkg::item_t                  item_q;
	logic [2:0]                      step_q;
	logic [7:0]                      dd_q, dp_q, ds_q;   // dividends, shifted out msb first
	logic [3:0]                      rd_q, rp_q, rs_q;   // division remainders
	logic [7:0]                      dly_q;
	logic [7:0]                      per_q;
	logic [8:0]                      sec_q;
	logic [2:0]                      k_q;
	logic [pbl_pkg::CNT_BITS-1:0]    cnt_q [pbl_pkg::NUM_CNT];
	logic [pbl_pkg::CNT_BITS-1:0]    n_q;
	logic [pbl_pkg::CNT_BITS-1:0]    nsh_q;
	logic [pbl_pkg::BCNT_W-1:0]      bcnt_q;
	logic [7:0]                      mp_q;
	logic [8:0]                      ms_q;
	logic [7:0]                      prim_q, sec8_q, long_q;

	// one restoring step for each of the three delay divisions
	logic [4:0] td, tp, ts;
	logic       qd, qp, qs;
	logic [4:0] spd5;
	always_comb begin
		spd5 = {1'b0, cfg.speed};
		td   = {rd_q, dd_q[7]};
		tp   = {rp_q, dp_q[7]};
		ts   = {rs_q, ds_q[7]};
		qd   = (td >= spd5);
		qp   = (tp >= spd5);
		qs   = (ts >= spd5);
	end

	// one remainder step for both repeat periods
	logic [8:0] up, up_s;
	logic [9:0] us, us_s;
	always_comb begin
		up   = {mp_q, nsh_q[pbl_pkg::CNT_BITS-1]};
		us   = {ms_q, nsh_q[pbl_pkg::CNT_BITS-1]};
		up_s = (up >= {1'b0, per_q}) ? up - {1'b0, per_q} : up;
		us_s = (us >= {1'b0, sec_q}) ? us - {1'b0, sec_q} : us;
	end

	// classify the counter just worked through
	logic [3:0]                  btn;
	logic                        cur_b;
	logic [pbl_pkg::CMP_W-1:0]   n_w;
	logic                        ge, lt2, in_band, p_bit, s_bit;
	always_comb begin
		btn     = pbl_pkg::btn_of(k_q);
		cur_b   = item_q.cur[btn];
		n_w     = pbl_pkg::CMP_W'(n_q);
		ge      = (n_w >= pbl_pkg::CMP_W'(dly_q));
		lt2     = (n_w < pbl_pkg::CMP_W'(2));
		in_band = !lt2 && (n_w < pbl_pkg::CMP_W'({dly_q, 1'b0}));
		p_bit   = cur_b && (ge ? (mp_q == 8'd0) : lt2);
		s_bit   = cur_b && (ge ? (ms_q == 9'd0 && !in_band) : lt2);
	end

	// assemble the result from the per-counter bits
	logic [31:0] act;
	logic [15:0] rep;
	always_comb begin
		act = {long_q[7:4], 8'd0, long_q[3:0], prim_q[7:4], 8'd0, prim_q[3:0]};
		act = (act & pbl_pkg::COUNTED_MASK) | {16'd0, item_q.held};
		rep = {sec8_q[7:4], 8'd0, sec8_q[3:0]} | item_q.held;
	end

	logic [pbl_pkg::OUT_W-1:0] out_d;
	assign out_d = {7'd0, item_q.rst_req, rep, act};

	assign pop       = (state_q == ST_IDLE) && !empty;
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = out_d;

	// sequencer with its registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= 3'd0;
			k_q     <= 3'd0;
			bcnt_q  <= '0;
			for (int i = 0; i < pbl_pkg::NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						item_q  <= item;
						dd_q    <= cfg.delay;
						dp_q    <= cfg.period;
						ds_q    <= cfg.second;
						rd_q    <= 4'd0;
						rp_q    <= 4'd0;
						rs_q    <= 4'd0;
						step_q  <= 3'd0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rd_q   <= qd ? 4'(td - spd5) : td[3:0];
					rp_q   <= qp ? 4'(tp - spd5) : tp[3:0];
					rs_q   <= qs ? 4'(ts - spd5) : ts[3:0];
					dd_q   <= {dd_q[6:0], qd};
					dp_q   <= {dp_q[6:0], qp};
					ds_q   <= {ds_q[6:0], qs};
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						dly_q   <= {dd_q[6:0], qd};
						per_q   <= ({dp_q[6:0], qp} == 8'd0) ? 8'd1 : {dp_q[6:0], qp};
						sec_q   <= {1'b0, ds_q[6:0], qs} + pbl_pkg::SEC_EXTRA;
						k_q     <= 3'd0;
						prim_q  <= 8'd0;
						sec8_q  <= 8'd0;
						long_q  <= 8'd0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (cur_b) begin
						cnt_q[k_q] <= cnt_q[k_q] + 1'b1;
						n_q        <= cnt_q[k_q] + 1'b1;
						nsh_q      <= cnt_q[k_q] + 1'b1;
					end else begin
						cnt_q[k_q] <= '0;
						n_q        <= '0;
						nsh_q      <= '0;
					end
					mp_q    <= 8'd0;
					ms_q    <= 9'd0;
					bcnt_q  <= '0;
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					mp_q   <= up_s[7:0];
					ms_q   <= us_s[8:0];
					nsh_q  <= nsh_q << 1;
					bcnt_q <= bcnt_q + 1'b1;
					if (bcnt_q == pbl_pkg::BCNT_W'(pbl_pkg::CNT_BITS - 1)) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					prim_q[k_q] <= p_bit;
					sec8_q[k_q] <= s_bit;
					long_q[k_q] <= ge;
					k_q         <= k_q + 3'd1;
					state_q     <= (k_q == 3'd7) ? ST_OUT : ST_LOAD;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/pad_button_latch_autorepeat_unit.sv */
`timescale 1ns / 1ps
// Top level: stream ports, configuration registers, front, queue and back.
// Sequence: a result becomes valid after the queue pop, the serial divider and, for each
//   hold counter, the load, remainder and evaluation states of the back part.
// Flow: the back takes a new sample only once its result is accepted; the queue holds two samples ahead.
// Reset: arst_n clears latch, timer, edge mask, hold counters, queue and sequencer;
//   the registers return to speed 1, delay 16, periods 4 and 4.
module pad_button_latch_autorepeat_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [15:0]                s_tdata,   // pad_buttons[15:0]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [pbl_pkg::OUT_W-1:0]  m_tdata,   // active_mask[31:0], repeat_mask[47:32], reset_request[48]
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic [3:0] speed_q;
	logic [7:0] delay_q;
	logic [7:0] period_q;
	logic [7:0] second_q;

	pbl_pkg::item_t fr_item, q_item;
	pbl_pkg::cfg_t  cfg;
	logic           push, pop, full, empty;

	assign pready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= 4'd1;
			delay_q  <= 8'd16;
			period_q <= 8'd4;
			second_q <= 8'd4;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				pbl_pkg::REG_SPEED:  speed_q  <= pwdata[3:0];
				pbl_pkg::REG_DELAY:  delay_q  <= pwdata[7:0];
				pbl_pkg::REG_PERIOD: period_q <= pwdata[7:0];
				pbl_pkg::REG_SECOND: second_q <= pwdata[7:0];
				default:             speed_q  <= speed_q;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			pbl_pkg::REG_SPEED:  prdata = {28'd0, speed_q};
			pbl_pkg::REG_DELAY:  prdata = {24'd0, delay_q};
			pbl_pkg::REG_PERIOD: prdata = {24'd0, period_q};
			pbl_pkg::REG_SECOND: prdata = {24'd0, second_q};
			default:             prdata = 32'd0;
		endcase
	end

	// speed zero counts as one
	assign cfg.speed  = (speed_q == 4'd0) ? 4'd1 : speed_q;
	assign cfg.delay  = delay_q;
	assign cfg.period = period_q;
	assign cfg.second = second_q;

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	pbl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (push),
		.pad    (s_tdata),
		.speed  (cfg.speed),
		.item   (fr_item)
	);

	pbl_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (fr_item),
		.pop    (pop),
		.rdata  (q_item),
		.full   (full),
		.empty  (empty)
	);

	pbl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.item      (q_item),
		.cfg       (cfg),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	// a pop only takes a stored entry
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue popped while empty");

	// no result is offered in the cycle after a new sample is taken up
	a_pop_busy: assert property (@(posedge clk) disable iff (!arst_n) pop |=> !m_tvalid)
		else $error("result offered right after pop");

	// a result is never offered while the back part is taking a sample
	a_out_no_pop: assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> !pop)
		else $error("pop while a result waits");

endmodule

/* dv/pad_button_latch_autorepeat_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the pad button latch with auto-repeat and long-press outputs.
module pad_button_latch_autorepeat_unit_test;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE = 200;

	// Frame predictor and store of expected result words
	class pad_scoreboard;
		logic [3:0]  speed;
		logic [7:0]  delay;
		logic [7:0]  period;
		logic [7:0]  second;
		logic [15:0] latched;
		logic [4:0]  timer;
		logic [15:0] prev_pressed;
		logic [pbl_pkg::CNT_BITS-1:0] holds [pbl_pkg::NUM_CNT];
		logic [48:0] pending [$];
		int errors;

		function new();
			speed = 4'd1;
			delay = 8'd16;
			period = 8'd4;
			second = 8'd4;
			latched = '0;
			timer = '0;
			prev_pressed = '0;
			foreach (holds[k]) holds[k] = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				pbl_pkg::REG_SPEED:  speed = val[3:0];
				pbl_pkg::REG_DELAY:  delay = val[7:0];
				pbl_pkg::REG_PERIOD: period = val[7:0];
				pbl_pkg::REG_SECOND: second = val[7:0];
				default: ;
			endcase
		endfunction

		// Advance the predicted state by one frame and queue its result
		function void note_frame(logic [15:0] pad);
			int unsigned spd, dly, per, sec, n, b;
			logic [15:0] cur, edges, held;
			logic [31:0] prim, secm, bitm;
			spd = (speed == 0) ? 1 : speed;
			dly = delay / spd;
			per = period / spd;
			sec = second / spd + pbl_pkg::SEC_EXTRA;
			if (per == 0) per = 1;
			cur = pad;
			if ((cur & latched) != 0) begin
				cur &= latched;
			end else if (cur == 0) begin
				latched = '0;
				timer = timer + spd[4:0];
			end else begin
				if (timer < pbl_pkg::TIMER_THR && (cur & pbl_pkg::DIR_MASK) != 0) begin
					cur &= pbl_pkg::DIR_MASK;
					timer = pbl_pkg::TIMER_MAX;
				end
				if (timer >= pbl_pkg::TIMER_THR) begin
					timer = '0;
					cur &= (~cur + 16'd1);
					latched = cur;
				end else begin
					cur = '0;
					latched = '0;
				end
			end
			if (timer >= pbl_pkg::TIMER_MAX) timer = pbl_pkg::TIMER_MAX;
			edges = cur & ~prev_pressed;
			prev_pressed = cur;
			prim = {16'h0, cur};
			secm = {16'h0, cur};
			for (int k = 0; k < pbl_pkg::NUM_CNT; k++) begin
				b = (k < 4) ? k : k + 8;
				bitm = 32'd1 << b;
				if (cur[b]) holds[k] = holds[k] + 1'b1;
				else holds[k] = '0;
				n = holds[k];
				if (n >= dly) begin
					if (n % per != 0) prim &= ~bitm;
					prim |= 32'd1 << (b + 16);
					if (n % sec != 0) secm &= ~bitm;
					else if (n >= 2 && n < 2 * dly) secm &= ~bitm;
				end else if (n >= 2) begin
					prim &= ~bitm;
					secm &= ~bitm;
				end
			end
			held = edges & pbl_pkg::EDGE_MASK;
			pending.push_back({(pad == pbl_pkg::RESET_COMBO),
				(secm[15:0] & pbl_pkg::COUNTED_MASK[15:0]) | held,
				(prim & pbl_pkg::COUNTED_MASK) | {16'h0, held}});
		endfunction

		// Compare one result with the oldest expectation
		function void check_result(logic [pbl_pkg::OUT_W-1:0] word);
			logic [48:0] want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", word[48:0]);
				return;
			end
			want = pending.pop_front();
			if (word[31:0] !== want[31:0] || word[47:32] !== want[47:32]
					|| word[48] !== want[48]) begin
				errors++;
				if (errors <= 10)
					$display("result: expected active %h repeat %h rst %b, got %h %h %b",
						want[31:0], want[47:32], want[48],
						word[31:0], word[47:32], word[48]);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [pbl_pkg::OUT_W-1:0] m_tdata;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	pad_scoreboard sb;
	int cycles;
	int send_idle_pct;
	int recv_idle_pct;
	logic [15:0] frames [$];

	pad_button_latch_autorepeat_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// Watch both streams and the cycle budget
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("pad_button_latch_autorepeat_unit: mismatch");
			$finish;
		end
		if (arst_n && s_tvalid && s_tready) sb.note_frame(s_tdata);
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// Stall the result side at random
	always @(posedge clk) begin
		if (arst_n) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic send_frame(input logic [15:0] pad);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pad;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Setup and access phases of one write; the caller releases the bus
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic set_config(input int spd, input int dly, input int per, input int sec);
		drain();
		write_reg(pbl_pkg::REG_SPEED, spd);
		write_reg(pbl_pkg::REG_DELAY, dly);
		write_reg(pbl_pkg::REG_PERIOD, per);
		write_reg(pbl_pkg::REG_SECOND, sec);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Queue one well-formed hold sequence, or noise, or the reset combination, or a direction press after an empty frame
	task automatic plan_sequence();
		int kind, len, b;
		logic [15:0] pad;
		kind = $urandom_range(0, 9);
		if (kind <= 6) begin
			b = ($urandom_range(0, 2) != 0) ? (($urandom_range(0, 1) != 0) ?
				$urandom_range(0, 3) : $urandom_range(12, 15)) : $urandom_range(4, 11);
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				pad = 16'd1 << b;
				if ($urandom_range(0, 3) == 0) pad |= 16'($urandom_range(0, 16'hffff));
				frames.push_back(pad);
			end
			repeat ($urandom_range(0, 3)) frames.push_back(16'h0);
		end else if (kind == 7) begin
			frames.push_back(16'($urandom_range(0, 16'hffff)));
		end else if (kind == 8) begin
			frames.push_back(pbl_pkg::RESET_COMBO);
		end else begin
			frames.push_back(16'h0);
			frames.push_back(16'(($urandom_range(1, 15) << 12) | $urandom_range(0, 16'h0fff)));
		end
	endtask

	initial begin
		int sent, phase;
		sb = new();
		cycles = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at reset settings: extremes, reset combination, holds, directions
		frames = {16'h0000, 16'hffff, 16'h0000, pbl_pkg::RESET_COMBO, 16'h0000, 16'hf00f,
			16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0000,
			16'h0010, 16'h0800, 16'h0000, 16'h8000, 16'h8001, 16'h8000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0002, 16'h0002};
		foreach (frames[i]) send_frame(frames[i]);
		frames.delete();

		// Zero delay sets long-press on all counted buttons; zero speed and period act as one
		set_config(0, 0, 0, 0);
		frames = {16'h0000, 16'h0004, 16'h0004, 16'h0004, 16'h0000};
		foreach (frames[i]) send_frame(frames[i]);
		frames.delete();

		sent = 0;
		phase = 0;
		while (sent < 800) begin
			if (sent >= phase * 160) begin
				case (phase)
					0: set_config(1, 16, 4, 4);
					1: set_config(15, 255, 255, 255);
					2: set_config(1, 3, 1, 1);
					3: set_config(2, $urandom_range(0, 12), $urandom_range(0, 6),
						$urandom_range(0, 6));
					default: set_config($urandom_range(0, 15), $urandom_range(0, 10),
						$urandom_range(0, 255), $urandom_range(0, 8));
				endcase
				phase++;
			end
			if (sent < 267) begin
				send_idle_pct = 29;
				recv_idle_pct = 47;
			end else if (sent < 534) begin
				send_idle_pct = 47;
				recv_idle_pct = 29;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			plan_sequence();
			while (frames.size() != 0) begin
				send_frame(frames.pop_front());
				sent++;
			end
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("pad_button_latch_autorepeat_unit: match");
		else
			$display("pad_button_latch_autorepeat_unit: mismatch");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/pbl_pkg.sv
hw/rtl/pbl_fifo.sv
hw/rtl/pbl_front.sv
hw/rtl/pbl_back.sv
hw/rtl/pad_button_latch_autorepeat_unit.sv
dv/pad_button_latch_autorepeat_unit_test.sv
